[hdl/convex_polygon_sat_overlap_defines.svh]
// Assertion helpers used by the checker file.
`ifndef CONVEX_POLYGON_SAT_OVERLAP_DEFINES_SVH
`define CONVEX_POLYGON_SAT_OVERLAP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CPS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/cps_pkg.sv]
`timescale 1ns / 1ps
package cps_pkg;

  localparam int COORD_BITS       = 16;
  localparam int NRM_BITS         = COORD_BITS + 1;
  localparam int PRD_BITS         = COORD_BITS + NRM_BITS;
  localparam int DOT_BITS         = PRD_BITS + 1;
  localparam int MAX_VERTICES_DEF = 16;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;

  typedef struct packed {
    logic                         hull_select;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic                         end_of_hull;
  } in_item_t;

  typedef struct packed {
    logic       hulls_overlap;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic hull;
    logic first;
  } proj_ctl_t;

endpackage

[hdl/convex_polygon_sat_overlap.sv]
`timescale 1ns / 1ps
// Convex polygon overlap test (separating axis, 2D).
// Input: one vertex item per accepted start (start high, busy low). hull_select
// picks hull A or B; vertices arrive in boundary order. A hull A item and a
// hull B item without end_of_hull are each stored while busy stays low.
// The B item with end_of_hull starts the test and raises busy unless A is empty.
// Test: each edge normal of A, then of B, is formed from two vertex reads,
// then every vertex of both hulls is streamed through one shared dot-product
// unit (two multipliers, one adder, min/max tracking), one vertex a cycle.
// The test stops on the first separating edge. Result: out_valid pulses for
// one cycle, in the cycle after the last check (or in the cycle after the
// starting item if a hull is empty). The receiver cannot stall; the result
// must be taken in that cycle. Vertices beyond MAX_VERTICES are dropped and
// flagged in status. Reset empties both hulls and returns to loading; vertex
// memories are not cleared.
module convex_polygon_sat_overlap import cps_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int AW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNTW = $clog2(MAX_VERTICES + 1);
  localparam int VW   = 2 * COORD_BITS;
  localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_VERTICES);

  typedef enum logic [2:0] {
    S_LOAD, S_EDGE0, S_EDGE1, S_EDGE2, S_SCAN, S_DRAIN, S_CHECK
  } state_t;

  state_t                     state_r;
  logic [CNTW-1:0]            cnt_a_r, cnt_b_r;
  logic                       ovf_r;
  logic [1:0]                 status_r;
  logic                       eh_r, sh_r;
  logic [AW-1:0]              ei_r, sk_r;
  logic signed [COORD_BITS-1:0] p0x_r, p0y_r;
  logic signed [NRM_BITS-1:0] nx_r, ny_r;
  proj_ctl_t                  s1_r;
  logic                       out_valid_r;
  out_item_t                  out_item_r;

  logic                       we_a, we_b;
  logic [VW-1:0]              wdata, rdata_a, rdata_b, vert;
  logic [AW-1:0]              raddr, ej;
  logic [CNTW-1:0]            ei_inc, sk_inc, cnt_e, cnt_s, cnt_b_add;
  logic                       e_last, s_last, ovf_b, rsel, separated;
  logic signed [COORD_BITS-1:0] vx, vy;
  logic                       proj_active;
  logic signed [DOT_BITS-1:0] min_a, max_a, min_b, max_b;
  logic                       out_valid_nxt;
  proj_ctl_t                  s1_nxt;

  assign busy = (state_r != S_LOAD);

  // vertex store
  assign wdata = {in_item.vertex_y, in_item.vertex_x};
  assign we_a  = start && !busy && !in_item.hull_select && (cnt_a_r < CNT_MAX);
  assign we_b  = start && !busy && in_item.hull_select && (cnt_b_r < CNT_MAX);

  assign cnt_b_add = (cnt_b_r < CNT_MAX) ? cnt_b_r + 1'b1 : cnt_b_r;
  assign ovf_b     = ovf_r || (cnt_b_r == CNT_MAX);

  // edge and scan indexing
  assign cnt_e  = eh_r ? cnt_b_r : cnt_a_r;
  assign ei_inc = CNTW'(ei_r) + 1'b1;
  assign e_last = (ei_inc == cnt_e);
  assign ej     = e_last ? '0 : ei_inc[AW-1:0];
  assign cnt_s  = sh_r ? cnt_b_r : cnt_a_r;
  assign sk_inc = CNTW'(sk_r) + 1'b1;
  assign s_last = (sk_inc == cnt_s);

  always_comb begin
    case (state_r)
      S_EDGE0: raddr = ei_r;
      S_EDGE1: raddr = ej;
      S_SCAN:  raddr = sk_r;
      default: raddr = ei_r;
    endcase
  end

  cps_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (cnt_a_r[AW-1:0]),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_a)
  );

  cps_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (cnt_b_r[AW-1:0]),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_b)
  );

  // read data belongs to the edge hull during edge fetch, else to the scan tag
  assign rsel = (state_r == S_EDGE1 || state_r == S_EDGE2) ? eh_r : s1_r.hull;
  assign vert = rsel ? rdata_b : rdata_a;
  assign vx   = vert[COORD_BITS-1:0];
  assign vy   = vert[VW-1:COORD_BITS];

  cps_proj u_proj (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (s1_r),
    .px     (vx),
    .py     (vy),
    .nx     (nx_r),
    .ny     (ny_r),
    .active (proj_active),
    .min_a  (min_a),
    .max_a  (max_a),
    .min_b  (min_b),
    .max_b  (max_b)
  );

  // touching intervals still overlap
  assign separated = (max_a < min_b) || (max_b < min_a);

  // result strobe: empty hull at the closing item, or end of the test
  assign out_valid_nxt = (state_r == S_LOAD && start && in_item.hull_select &&
                          in_item.end_of_hull && (cnt_a_r == '0 || cnt_b_add == '0)) ||
                         (state_r == S_CHECK && (separated || (e_last && eh_r)));

  always_comb begin
    s1_nxt = '0;
    if (state_r == S_SCAN) begin
      s1_nxt = '{valid: 1'b1, hull: sh_r, first: (sk_r == '0)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      ovf_r       <= 1'b0;
      s1_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      s1_r        <= s1_nxt;
      case (state_r)
        S_LOAD: begin
          if (start) begin
            if (!in_item.hull_select) begin
              if (cnt_a_r < CNT_MAX) cnt_a_r <= cnt_a_r + 1'b1;
              else                   ovf_r   <= 1'b1;
            end else if (!in_item.end_of_hull) begin
              cnt_b_r <= cnt_b_add;
              ovf_r   <= ovf_b;
            end else if (cnt_a_r == '0 || cnt_b_add == '0) begin
              out_item_r.hulls_overlap <= 1'b0;
              out_item_r.status        <= ST_EMPTY;
              cnt_a_r                  <= '0;
              cnt_b_r                  <= '0;
              ovf_r                    <= 1'b0;
            end else begin
              cnt_b_r  <= cnt_b_add;
              status_r <= ovf_b ? ST_DROPPED : ST_OK;
              eh_r     <= 1'b0;
              ei_r     <= '0;
              state_r  <= S_EDGE0;
            end
          end
        end
        S_EDGE0: state_r <= S_EDGE1;
        S_EDGE1: begin
          p0x_r   <= vx;
          p0y_r   <= vy;
          state_r <= S_EDGE2;
        end
        S_EDGE2: begin
          // normal of edge i -> j is (yj - yi, xi - xj)
          nx_r    <= NRM_BITS'(vy) - NRM_BITS'(p0y_r);
          ny_r    <= NRM_BITS'(p0x_r) - NRM_BITS'(vx);
          sh_r    <= 1'b0;
          sk_r    <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (s_last) begin
            if (!sh_r) begin
              sh_r <= 1'b1;
              sk_r <= '0;
            end else begin
              state_r <= S_DRAIN;
            end
          end else begin
            sk_r <= sk_inc[AW-1:0];
          end
        end
        S_DRAIN: begin
          if (!s1_r.valid && !proj_active) state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (separated || (e_last && eh_r)) begin
            out_item_r.hulls_overlap <= !separated;
            out_item_r.status        <= status_r;
            cnt_a_r                  <= '0;
            cnt_b_r                  <= '0;
            ovf_r                    <= 1'b0;
            state_r                  <= S_LOAD;
          end else if (e_last) begin
            eh_r    <= 1'b1;
            ei_r    <= '0;
            state_r <= S_EDGE0;
          end else begin
            ei_r    <= ei_inc[AW-1:0];
            state_r <= S_EDGE0;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[hdl/cps_ram.sv]
`timescale 1ns / 1ps
module cps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/cps_proj.sv]
`timescale 1ns / 1ps
module cps_proj import cps_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  proj_ctl_t                  ctl,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  input  logic signed [NRM_BITS-1:0]   nx,
  input  logic signed [NRM_BITS-1:0]   ny,
  output logic                       active,
  output logic signed [DOT_BITS-1:0] min_a,
  output logic signed [DOT_BITS-1:0] max_a,
  output logic signed [DOT_BITS-1:0] min_b,
  output logic signed [DOT_BITS-1:0] max_b
);

  proj_ctl_t                  ctl_r;
  logic signed [PRD_BITS-1:0] prod_x_r, prod_y_r;
  logic signed [DOT_BITS-1:0] min_a_r, max_a_r, min_b_r, max_b_r;
  logic signed [DOT_BITS-1:0] dot;

  assign dot = DOT_BITS'(prod_x_r) + DOT_BITS'(prod_y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
    prod_x_r <= PRD_BITS'(px) * PRD_BITS'(nx);
    prod_y_r <= PRD_BITS'(py) * PRD_BITS'(ny);
    // first vertex of a hull seeds both bounds
    if (ctl_r.valid && !ctl_r.hull) begin
      if (ctl_r.first || dot < min_a_r) min_a_r <= dot;
      if (ctl_r.first || dot > max_a_r) max_a_r <= dot;
    end
    if (ctl_r.valid && ctl_r.hull) begin
      if (ctl_r.first || dot < min_b_r) min_b_r <= dot;
      if (ctl_r.first || dot > max_b_r) max_b_r <= dot;
    end
  end

  assign active = ctl_r.valid;
  assign min_a  = min_a_r;
  assign max_a  = max_a_r;
  assign min_b  = min_b_r;
  assign max_b  = max_b_r;

endmodule

[hdl/cps_checker.sv]
`timescale 1ns / 1ps
`include "convex_polygon_sat_overlap_defines.svh"
module cps_checker import cps_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_item,
  input logic      out_valid,
  input out_item_t out_item
);

  `CPS_ASSERT_IMPL(a_empty_no_overlap, out_valid && (out_item.status == ST_EMPTY), !out_item.hulls_overlap, "empty hull reported overlap")
  `CPS_ASSERT_IMPL(a_result_when_idle, out_valid, !busy, "result shown while test still busy")
  `CPS_ASSERT_NEXT(a_hull_a_no_result, start && !busy && !in_item.hull_select, !out_valid, "hull A item produced a result")
  `CPS_ASSERT_NEXT(a_end_b_starts, start && !busy && in_item.hull_select && in_item.end_of_hull, out_valid || busy, "closing hull B item neither tested nor reported")

endmodule

bind convex_polygon_sat_overlap cps_checker u_cps_checker (.*);
